[rtl/core/lcdls_pkg.sv]
// Package for the LCD line and mode sequencer: request, mode and register
// codes, reset values, the state and result structs. No dependencies.
package lcdls_pkg;

  // Request codes carried in the mode field of an input beat
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_PHASE = 2'd2;

  // Display modes held in status bits 1..0
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Display register indexes
  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_STATUS   = 3'd1;
  localparam logic [2:0] REG_SCROLL_Y = 3'd2;
  localparam logic [2:0] REG_SCROLL_X = 3'd3;
  localparam logic [2:0] REG_LINE     = 3'd4;
  localparam logic [2:0] REG_COMPARE  = 3'd5;
  localparam logic [2:0] REG_WINDOW_Y = 3'd6;
  localparam logic [2:0] REG_WINDOW_X = 3'd7;

  // Configuration register indexes
  localparam logic CFG_COLOUR_MODE = 1'b0;

  // Reset values and masks
  localparam logic [7:0] CONTROL_RESET    = 8'h91;
  localparam logic [7:0] STATUS_RESET     = 8'h85;
  localparam logic [7:0] STATUS_WR_MASK   = 8'b1111_1000;
  localparam logic [7:0] STATUS_KEEP_MASK = 8'b0000_0111;

  // Line numbers with special handling
  localparam logic [7:0] LINE_LAST_VISIBLE = 8'd143;
  localparam logic [7:0] LINE_LAST         = 8'd153;
  localparam logic [7:0] WINDOW_X_MAX      = 8'd166;

  // Status and control bit positions
  localparam int unsigned ST_MATCH  = 2;
  localparam int unsigned ST_HB_IE  = 3;
  localparam int unsigned ST_VB_IE  = 4;
  localparam int unsigned ST_OAM_IE = 5;
  localparam int unsigned ST_CMP_IE = 6;
  localparam int unsigned CT_BG_EN  = 0;
  localparam int unsigned CT_WIN_EN = 5;
  localparam int unsigned CT_LCD_EN = 7;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] status;
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic [7:0] line;
    logic [7:0] compare;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] window_line;
  } lcd_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } req_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       lcd_irq;
    logic [1:0] display_mode;
    logic [7:0] current_line;
    logic       frame_done;
  } res_beat_t;

endpackage

[rtl/core/lcdls_cfg.sv]
// APB-style configuration port holding the colour mode bit.
// Depends on lcdls_pkg.
module lcdls_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic        colour_mode
);
  import lcdls_pkg::*;

  logic colour_mode_r;
  logic colour_mode_nxt;
  logic wr_en;
  logic hit;

  // register 0 sits at byte 0; bit 2 selects the word
  assign hit   = (cfg_paddr[2] == CFG_COLOUR_MODE);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    colour_mode_nxt = colour_mode_r;
    if (wr_en && hit) begin
      colour_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_mode_r <= 1'b0;
    end else begin
      colour_mode_r <= colour_mode_nxt;
    end
  end

  assign cfg_prdata  = hit ? {31'd0, colour_mode_r} : 32'd0;
  assign cfg_pready  = 1'b1;
  assign colour_mode = colour_mode_r;

endmodule

[rtl/core/lcdls_step.sv]
// Next-state and result logic for one request beat: register access or
// mode step with line compare. Depends on lcdls_pkg.
module lcdls_step (
  input  lcdls_pkg::lcd_state_t st,
  input  lcdls_pkg::req_beat_t  req,
  input  logic                  colour_mode,
  output lcdls_pkg::lcd_state_t st_nxt,
  output lcdls_pkg::res_beat_t  res
);
  import lcdls_pkg::*;

  always_comb begin
    logic [7:0] line_inc;
    logic       win_vis;
    logic       vb;
    logic       lcd;
    logic       frame;
    logic       do_cmp;
    logic [7:0] rd;

    line_inc = st.line + 8'd1;
    win_vis  = colour_mode || st.control[CT_BG_EN];
    vb       = 1'b0;
    lcd      = 1'b0;
    frame    = 1'b0;
    do_cmp   = 1'b0;
    rd       = 8'd0;
    st_nxt   = st;

    unique case (req.mode)
      // register read
      REQ_READ: begin
        unique case (req.reg_index)
          REG_CONTROL:  rd = st.control;
          REG_STATUS:   rd = st.status;
          REG_SCROLL_Y: rd = st.scroll_y;
          REG_SCROLL_X: rd = st.scroll_x;
          REG_LINE:     rd = st.line;
          REG_COMPARE:  rd = st.compare;
          REG_WINDOW_Y: rd = st.window_y;
          REG_WINDOW_X: rd = st.window_x;
          default:      rd = st.window_x;
        endcase
      end
      // register write; status keeps its mode and match bits
      REQ_WRITE: begin
        unique case (req.reg_index)
          REG_CONTROL:  st_nxt.control = req.write_data;
          REG_STATUS:   st_nxt.status  = (req.write_data & STATUS_WR_MASK) |
                                         (st.status & STATUS_KEEP_MASK);
          REG_SCROLL_Y: st_nxt.scroll_y = req.write_data;
          REG_SCROLL_X: st_nxt.scroll_x = req.write_data;
          REG_LINE:     st_nxt.line     = req.write_data;
          REG_COMPARE:  st_nxt.compare  = req.write_data;
          REG_WINDOW_Y: st_nxt.window_y = req.write_data;
          REG_WINDOW_X: st_nxt.window_x = req.write_data;
          default:      st_nxt.window_x = req.write_data;
        endcase
      end
      // phase end: step the mode
      REQ_PHASE: begin
        unique case (st.status[1:0])
          MODE_OAM: begin
            st_nxt.status[1:0] = MODE_DRAW;
          end
          MODE_DRAW: begin
            if (st.control[CT_LCD_EN] && win_vis && st.control[CT_WIN_EN] &&
                (st.window_x <= WINDOW_X_MAX) && (st.window_y <= st.line)) begin
              st_nxt.window_line = st.window_line + 8'd1;
            end
            st_nxt.status[1:0] = MODE_HBLANK;
            lcd = st.status[ST_HB_IE];
          end
          MODE_HBLANK: begin
            if (st.line == LINE_LAST_VISIBLE) begin
              st_nxt.status[1:0] = MODE_VBLANK;
              frame = 1'b1;
              vb    = 1'b1;
              lcd   = st.status[ST_VB_IE];
            end else begin
              st_nxt.status[1:0] = MODE_OAM;
              lcd = st.status[ST_OAM_IE];
            end
            st_nxt.line = line_inc;
            do_cmp = 1'b1;
          end
          MODE_VBLANK: begin
            if (st.line == LINE_LAST) begin
              st_nxt.line        = 8'd0;
              st_nxt.window_line = 8'd0;
              st_nxt.status[1:0] = MODE_OAM;
            end else begin
              st_nxt.line = line_inc;
            end
            do_cmp = 1'b1;
          end
          default: begin
            st_nxt.status[1:0] = st.status[1:0];
          end
        endcase
      end
      // unused request code leaves everything as it is
      default: begin
        st_nxt = st;
      end
    endcase

    // line compare after a line change
    if (do_cmp) begin
      if (st_nxt.line == st.compare) begin
        st_nxt.status[ST_MATCH] = 1'b1;
        lcd = lcd | st.status[ST_CMP_IE];
      end else begin
        st_nxt.status[ST_MATCH] = 1'b0;
      end
    end

    res.read_data    = rd;
    res.vblank_irq   = vb;
    res.lcd_irq      = lcd;
    res.display_mode = st_nxt.status[1:0];
    res.current_line = st_nxt.line;
    res.frame_done   = frame;
  end

endmodule

[rtl/core/lcd_line_mode_sequencer_unit.sv]
// Top level of the LCD line and mode sequencer: input register, state
// registers, result register. Depends on lcdls_pkg, lcdls_cfg, lcdls_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | in        | in_valid/in_stall  | mode, reg_index, write_data
//  out_    | out       | out_valid/out_stall| read_data, vblank_irq, lcd_irq,
//          |           |                    | display_mode, current_line,
//          |           |                    | frame_done
//  cfg_    | in/out    | APB psel/penable   | colour_mode at byte 0
//
// One beat per cycle while the output is not stalled; a beat passes the input
// register, then the step logic into the result register.
// The display state updates at the same edge that loads the result, so the
// next beat in the input register always sees it.
// A stall on the output holds both stages; the input stalls only when its
// register is full and cannot move on. Reset is synchronous, active low.
module lcd_line_mode_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_vblank_irq,
  output logic        out_lcd_irq,
  output logic [1:0]  out_display_mode,
  output logic [7:0]  out_current_line,
  output logic        out_frame_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lcdls_pkg::*;

  logic       colour_mode;
  logic       in_valid_r;
  req_beat_t  req_r;
  logic       out_valid_r;
  res_beat_t  res_r;
  lcd_state_t st_r;
  lcd_state_t st_nxt;
  res_beat_t  res_nxt;
  logic       adv;
  logic       in_take;

  lcdls_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .colour_mode (colour_mode)
  );

  lcdls_step u_step (
    .st          (st_r),
    .req         (req_r),
    .colour_mode (colour_mode),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  // stage control
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.mode       <= in_mode;
      req_r.reg_index  <= in_reg_index;
      req_r.write_data <= in_write_data;
    end
  end

  // display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.control     <= CONTROL_RESET;
      st_r.status      <= STATUS_RESET;
      st_r.scroll_y    <= 8'd0;
      st_r.scroll_x    <= 8'd0;
      st_r.line        <= 8'd0;
      st_r.compare     <= 8'd0;
      st_r.window_y    <= 8'd0;
      st_r.window_x    <= 8'd0;
      st_r.window_line <= 8'd0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_vblank_irq   = res_r.vblank_irq;
  assign out_lcd_irq      = res_r.lcd_irq;
  assign out_display_mode = res_r.display_mode;
  assign out_current_line = res_r.current_line;
  assign out_frame_done   = res_r.frame_done;

`ifndef SYNTHESIS
  // a beat moving on always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after advance");

  // state only changes when a beat moves through the step logic
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("display state changed without a beat");

  // frame end result enters vertical blank on line 144 with its interrupt
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_done) |->
      (res_r.vblank_irq && (res_r.display_mode == MODE_VBLANK) &&
       (res_r.current_line == LINE_LAST_VISIBLE + 8'd1)))
    else $error("frame done without vertical blank entry");

  // result register mode and line match the state that the beat produced
  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (res_r.display_mode == st_r.status[1:0]) &&
            (res_r.current_line == st_r.line))
    else $error("result mode or line differs from stored state");
`endif

endmodule

[tb/sv/lcd_mode_tracker_pkg.sv]
// Display-state tracker for the LCD line and mode sequencer bench: keeps its
// own register file, predicts the result beat of each request and checks it.
// Depends on lcdls_pkg.
package lcd_mode_tracker_pkg;
  import lcdls_pkg::*;

  // Request code outside the defined set; state must be left alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  class lcd_mode_tracker;
    logic       colour_mode;
    lcd_state_t regs;
    res_beat_t  due_q[$];
    int         mismatches;

    function new();
      colour_mode = 1'b0;
      regs = '0;
      regs.control = CONTROL_RESET;
      regs.status = STATUS_RESET;
      mismatches = 0;
    endfunction

    function void set_colour_mode(logic v);
      colour_mode = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function logic [7:0] line_now();
      return regs.line;
    endfunction

    // Line changed: refresh the match flag, report a compare interrupt
    function logic recheck_compare();
      if (regs.line == regs.compare) begin
        regs.status[ST_MATCH] = 1'b1;
        return regs.status[ST_CMP_IE];
      end
      regs.status[ST_MATCH] = 1'b0;
      return 1'b0;
    endfunction

    // Apply one request to the display state, return the beat it yields
    function res_beat_t step_display(req_beat_t rq);
      res_beat_t r;
      r = '0;
      case (rq.mode)
        REQ_READ: begin
          case (rq.reg_index)
            REG_CONTROL:  r.read_data = regs.control;
            REG_STATUS:   r.read_data = regs.status;
            REG_SCROLL_Y: r.read_data = regs.scroll_y;
            REG_SCROLL_X: r.read_data = regs.scroll_x;
            REG_LINE:     r.read_data = regs.line;
            REG_COMPARE:  r.read_data = regs.compare;
            REG_WINDOW_Y: r.read_data = regs.window_y;
            default:      r.read_data = regs.window_x;
          endcase
        end
        REQ_WRITE: begin
          case (rq.reg_index)
            REG_CONTROL:  regs.control = rq.write_data;
            REG_STATUS:   regs.status = (rq.write_data & STATUS_WR_MASK) |
                                        (regs.status & STATUS_KEEP_MASK);
            REG_SCROLL_Y: regs.scroll_y = rq.write_data;
            REG_SCROLL_X: regs.scroll_x = rq.write_data;
            REG_LINE:     regs.line = rq.write_data;
            REG_COMPARE:  regs.compare = rq.write_data;
            REG_WINDOW_Y: regs.window_y = rq.write_data;
            default:      regs.window_x = rq.write_data;
          endcase
        end
        REQ_PHASE: begin
          case (regs.status[1:0])
            MODE_OAM: begin
              regs.status[1:0] = MODE_DRAW;
            end
            MODE_DRAW: begin
              // window line advances only when the window is on this line
              if (regs.control[CT_LCD_EN] && (colour_mode || regs.control[CT_BG_EN]) &&
                  regs.control[CT_WIN_EN] && regs.window_x <= WINDOW_X_MAX &&
                  regs.window_y <= regs.line)
                regs.window_line = regs.window_line + 8'd1;
              regs.status[1:0] = MODE_HBLANK;
              r.lcd_irq = regs.status[ST_HB_IE];
            end
            MODE_HBLANK: begin
              if (regs.line == LINE_LAST_VISIBLE) begin
                regs.status[1:0] = MODE_VBLANK;
                r.frame_done = 1'b1;
                r.vblank_irq = 1'b1;
                r.lcd_irq = regs.status[ST_VB_IE];
              end else begin
                regs.status[1:0] = MODE_OAM;
                r.lcd_irq = regs.status[ST_OAM_IE];
              end
              regs.line = regs.line + 8'd1;
              if (recheck_compare()) r.lcd_irq = 1'b1;
            end
            default: begin
              // vertical blank: wrap to the top after the last line
              if (regs.line == LINE_LAST) begin
                regs.line = 8'd0;
                regs.window_line = 8'd0;
                regs.status[1:0] = MODE_OAM;
              end else begin
                regs.status[1:0] = MODE_VBLANK;
                regs.line = regs.line + 8'd1;
              end
              if (recheck_compare()) r.lcd_irq = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
      r.display_mode = regs.status[1:0];
      r.current_line = regs.line;
      return r;
    endfunction

    function void take_request(req_beat_t rq);
      due_q.push_back(step_display(rq));
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_beat_t got);
      res_beat_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none, got %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      field_check("read_data", want.read_data, got.read_data);
      field_check("vblank_irq", want.vblank_irq, got.vblank_irq);
      field_check("lcd_irq", want.lcd_irq, got.lcd_irq);
      field_check("display_mode", want.display_mode, got.display_mode);
      field_check("current_line", want.current_line, got.current_line);
      field_check("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

endpackage

[tb/sv/tb_lcd_line_mode_sequencer_unit.sv]
// Bench for lcd_line_mode_sequencer_unit: directed then random requests with
// random gaps and output stalls, checked beat by beat against the tracker.
// Depends on lcdls_pkg and lcd_mode_tracker_pkg.
module tb_lcd_line_mode_sequencer_unit;
  import lcdls_pkg::*;
  import lcd_mode_tracker_pkg::*;

  localparam int ITEMS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT     = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = REQ_READ;
  logic [2:0]  in_reg_index = REG_CONTROL;
  logic [7:0]  in_write_data = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_vblank_irq;
  logic        out_lcd_irq;
  logic [1:0]  out_display_mode;
  logic [7:0]  out_current_line;
  logic        out_frame_done;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lcd_mode_tracker tracker;
  bit in_quiet = 1'b0;
  int stall_hold = 0;
  int stall_pick;
  int phase_no;

  lcd_line_mode_sequencer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_vblank_irq   (out_vblank_irq),
    .out_lcd_irq      (out_lcd_irq),
    .out_display_mode (out_display_mode),
    .out_current_line (out_current_line),
    .out_frame_done   (out_frame_done),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output stall pattern: short runs, a few long stalls, long free stretches
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 8);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 30);
      end else begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(40, 80);
      end
    end
  end

  // Result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({out_read_data, out_vblank_irq, out_lcd_irq,
                            out_display_mode, out_current_line, out_frame_done});
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input beat; valid stays high when no gap follows
  task automatic send_request(logic [1:0] rq, logic [2:0] idx, logic [7:0] data, int gap);
    in_valid <= 1'b1;
    in_mode <= rq;
    in_reg_index <= idx;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    tracker.take_request({rq, idx, data});
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_colour_mode(logic v);
    logic [31:0] word;
    word = $urandom();
    word[0] = v;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * int'(CFG_COLOUR_MODE));
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.set_colour_mode(v);
    @(posedge clk);
  endtask

  // Extremes of the fields and the mode transitions but hblank to oam scan, incl. the wrap cases
  task automatic run_directed();
    for (int i = 0; i < 8; i++) send_request(REQ_READ, 3'(i), 8'h00, pick_gap());
    send_request(REQ_WRITE, REG_STATUS, 8'hFF, pick_gap());
    send_request(REQ_WRITE, REG_LINE, LINE_LAST, pick_gap());
    send_request(REQ_PHASE, REG_CONTROL, 8'h00, pick_gap());   // vblank end at last line
    send_request(REQ_PHASE, REG_WINDOW_X, 8'hFF, pick_gap());  // oam scan to draw
    send_request(REQ_WRITE, REG_WINDOW_X, WINDOW_X_MAX, pick_gap());
    send_request(REQ_WRITE, REG_CONTROL, 8'hFF, pick_gap());
    send_request(REQ_PHASE, REG_CONTROL, 8'h00, pick_gap());   // draw end, window counts
    send_request(REQ_WRITE, REG_LINE, LINE_LAST_VISIBLE, pick_gap());
    send_request(REQ_PHASE, REG_CONTROL, 8'h00, pick_gap());   // into vblank, frame done
    send_request(REQ_WRITE, REG_LINE, 8'hFF, pick_gap());
    send_request(REQ_PHASE, REG_CONTROL, 8'h00, pick_gap());   // line wraps in vblank
    send_request(REQ_UNUSED, REG_WINDOW_X, 8'hFF, pick_gap());
    send_request(REQ_WRITE, REG_STATUS, 8'h00, pick_gap());
    send_request(REQ_READ, REG_STATUS, 8'hFF, pick_gap());
    send_request(REQ_WRITE, REG_COMPARE, 8'hFF, pick_gap());
    send_request(REQ_WRITE, REG_SCROLL_X, 8'hAA, pick_gap());
    send_request(REQ_READ, REG_SCROLL_X, 8'h55, pick_gap());
  endtask

  // Mostly phase ends and line jumps near the frame boundaries
  task automatic random_request();
    int pick;
    logic [1:0] rq;
    logic [2:0] idx;
    logic [7:0] data;
    pick = $urandom_range(0, 99);
    rq = REQ_WRITE;
    idx = 3'($urandom_range(0, 7));
    data = 8'($urandom_range(0, 255));
    if (pick < 55) begin
      rq = REQ_PHASE;
    end else if (pick < 70) begin
      rq = REQ_READ;
    end else if (pick < 80) begin
      idx = REG_LINE;
      case ($urandom_range(0, 3))
        0, 1:    data = 8'($urandom_range(138, 155));
        2:       data = 8'hFF;
        default: ;
      endcase
    end else if (pick < 85) begin
      idx = REG_COMPARE;
      if ($urandom_range(0, 3) != 0) data = tracker.line_now() + 8'($urandom_range(0, 3));
    end else if (pick < 90) begin
      idx = REG_STATUS;
    end else if (pick < 94) begin
      idx = REG_CONTROL;
      data[7] = ($urandom_range(0, 3) != 0);
      data[5] = ($urandom_range(0, 3) != 0);
    end else if (pick < 97) begin
      idx = $urandom_range(0, 1) ? REG_WINDOW_X : REG_WINDOW_Y;
      if (idx == REG_WINDOW_X && $urandom_range(0, 1)) data = 8'($urandom_range(160, 172));
    end else if (pick < 99) begin
      rq = REQ_WRITE;
    end else begin
      rq = REQ_UNUSED;
    end
    if ($urandom_range(0, 19) == 0) in_quiet = !in_quiet;
    send_request(rq, idx, data, pick_gap());
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    write_colour_mode(1'b0);
    run_directed();
    // each phase starts from an idle block with a fresh colour setting
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      wait_drained();
      write_colour_mode(phase_no[0] ? 1'b0 : 1'b1);
      repeat (ITEMS_PER_PHASE) random_request();
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
